FILE: sv/csa_pkg.sv
// Shared types and constants for the contiguous segment allocator.
// Used by csa_cell and contiguous_segment_allocator_top; no dependencies.
package csa_pkg;

	localparam int ADDR_BITS    = 20;
	localparam int SIZE_W       = ADDR_BITS + 1;
	localparam int OWNER_BITS   = 8;
	localparam int MAX_SEGMENTS = 64;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = IDX_W + 1;

	localparam logic [SIZE_W-1:0] MEM_MAX = SIZE_W'(1) << ADDR_BITS;
	localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(MAX_SEGMENTS - 1);
	localparam logic [CNT_W-1:0]  SEG_FULL = CNT_W'(MAX_SEGMENTS);

	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_COMPACT = 2'd2;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_SPACE   = 3'd1;
	localparam logic [2:0] ST_NO_OWNER   = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_BAD        = 3'd4;

	localparam logic [2:0] CMD_HOLD = 3'd0;
	localparam logic [2:0] CMD_ROT  = 3'd1;
	localparam logic [2:0] CMD_INS  = 3'd2;
	localparam logic [2:0] CMD_DEL  = 3'd3;
	localparam logic [2:0] CMD_WR   = 3'd4;
	localparam logic [2:0] CMD_MARK = 3'd5;
	localparam logic [2:0] CMD_SORT = 3'd6;

	localparam logic [0:0] REG_POOL_UNITS = 1'd0;

	typedef struct packed {
		logic [ADDR_BITS-1:0]  seg_start;
		logic [ADDR_BITS-1:0]  seg_end;
		logic                  used;
		logic [OWNER_BITS-1:0] owner;
		logic                  keep;
	} entry_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic [IDX_W-1:0] pos;
		logic             phase;
		entry_t           wr;
	} cell_cmd_t;

	function automatic logic [SIZE_W-1:0] seg_len(entry_t e);
		seg_len = {1'b0, e.seg_end} - {1'b0, e.seg_start} + SIZE_W'(1);
	endfunction

endpackage

FILE: sv/csa_cell.sv
// One table slot of the segment chain: holds an entry and takes a neighbor's
// entry on rotate, insert, delete and sort steps. Depends on csa_pkg.
module csa_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [csa_pkg::IDX_W-1:0] idx,
	input  logic [csa_pkg::CNT_W-1:0] total,
	input  csa_pkg::cell_cmd_t      cmd,
	input  csa_pkg::entry_t         lo,
	input  csa_pkg::entry_t         hi,
	output csa_pkg::entry_t         q
);
	import csa_pkg::*;

	entry_t q_q;
	entry_t nxt;

	assign q = q_q;

	always_comb begin
		nxt = q_q;
		case (cmd.mode)
			CMD_ROT: nxt = hi;
			CMD_INS: begin
				if (idx > cmd.pos) nxt = lo;
			end
			CMD_DEL: begin
				if (idx >= cmd.pos) nxt = hi;
			end
			CMD_WR: begin
				if (idx == cmd.pos) nxt = cmd.wr;
			end
			CMD_MARK: nxt.keep = q_q.used && ({1'b0, idx} < total);
			CMD_SORT: begin
				// pair with the upper neighbor on matching parity, else the lower one
				if (idx[0] == cmd.phase) begin
					if (idx != IDX_LAST && !q_q.keep && hi.keep) nxt = hi;
				end else begin
					if (idx != '0 && !lo.keep && q_q.keep) nxt = lo;
				end
			end
			default: nxt = q_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '{seg_start: '0, seg_end: ADDR_BITS'(MEM_MAX - SIZE_W'(1)),
				used: 1'b0, owner: '0, keep: 1'b0};
		end else begin
			q_q <= nxt;
		end
	end

endmodule

FILE: sv/contiguous_segment_allocator_top.sv
// Contiguous segment allocator: a chain of 64 table cells plus a sequencer.
// Request, release, bad op: after acceptance, a scan rotation, a decide step,
// up to three insert/write/delete steps plus one, a sum rotation, then the output register.
// Compaction: mark, 64 odd-even sort steps, two rotations (compact, sum), output.
// One transaction at a time: the next is accepted only once the result is registered
// and the sequencer is back in idle. Reset: one free segment of 2^20 units.
module contiguous_segment_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic [csa_pkg::OWNER_BITS-1:0] owner_id,
	input  logic [csa_pkg::SIZE_W-1:0]    request_size,
	input  logic [1:0]                    fit_mode,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [csa_pkg::ADDR_BITS-1:0] start_address,
	output logic [csa_pkg::SIZE_W-1:0]    free_total,
	output logic [csa_pkg::CNT_W-1:0]     segment_count
);
	import csa_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_DECIDE = 4'd2;
	localparam logic [3:0] S_EXEC   = 4'd3;
	localparam logic [3:0] S_MARK   = 4'd4;
	localparam logic [3:0] S_SORT   = 4'd5;
	localparam logic [3:0] S_CPASS  = 4'd6;
	localparam logic [3:0] S_SUM    = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	entry_t    e [MAX_SEGMENTS];
	entry_t    head_in;
	cell_cmd_t cmd;

	logic [3:0]            state_q;
	logic [CNT_W-1:0]      total_q;
	logic [SIZE_W-1:0]     mem_q;
	logic [IDX_W-1:0]      k_q;
	logic [1:0]            op_q, mode_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [SIZE_W-1:0]     size_q;

	logic                  found_q;
	logic [IDX_W-1:0]      pick_q;
	logic [ADDR_BITS-1:0]  pick_start_q, pick_end_q;
	logic [SIZE_W-1:0]     pick_len_q;

	logic                  rel_found_q, need_next_q;
	logic [IDX_W-1:0]      r_q;
	logic [ADDR_BITS-1:0]  last_start_q, p_start_q, r_start_q, r_end_q, n_end_q;
	logic                  last_used_q, p_used_q, n_valid_q, n_used_q;

	logic                  ins_p_q, wra_p_q, wrb_p_q, dela_p_q, delb_p_q;
	logic [IDX_W-1:0]      wra_pos_q, wrb_pos_q, dela_pos_q, delb_pos_q;
	entry_t                wra_d_q, wrb_d_q;

	logic [SIZE_W-1:0]     sum_q, addr_q;
	logic [CNT_W-1:0]      w_q;
	logic                  hole_q;
	logic [2:0]            status_q;
	logic [ADDR_BITS-1:0]  grant_q;

	logic                  out_valid_q;
	logic [2:0]            status_o_q;
	logic [ADDR_BITS-1:0]  start_o_q;
	logic [SIZE_W-1:0]     free_o_q;
	logic [CNT_W-1:0]      count_o_q;

	logic                  cfg_wr;
	logic [SIZE_W-1:0]     cfg_size;
	logic [SIZE_W-1:0]     head_len;
	logic                  in_range;
	logic                  fit;
	logic [ADDR_BITS-1:0]  rel_end;

	// chain of cells
	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		csa_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.idx   (IDX_W'(i)),
			.total (total_q),
			.cmd   (cmd),
			.lo    (e[(i == 0) ? 0 : i - 1]),
			.hi    ((i == MAX_SEGMENTS - 1) ? head_in : e[(i == MAX_SEGMENTS - 1) ? 0 : i + 1]),
			.q     (e[i])
		);
	end

	assign pready   = 1'b1;
	assign prdata   = {{(32 - SIZE_W){1'b0}}, mem_q};
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_POOL_UNITS);
	assign cfg_size = (pwdata == 32'd0) ? SIZE_W'(1) :
		(pwdata > {{(32 - SIZE_W){1'b0}}, MEM_MAX}) ? MEM_MAX : pwdata[SIZE_W-1:0];

	assign in_ready      = (state_q == S_IDLE) && !cfg_wr;
	assign out_valid     = out_valid_q;
	assign status        = status_o_q;
	assign start_address = start_o_q;
	assign free_total    = free_o_q;
	assign segment_count = count_o_q;

	assign head_len = seg_len(e[0]);
	assign in_range = {1'b0, k_q} < total_q;
	assign fit      = in_range && !e[0].used && (head_len >= size_q);
	assign rel_end  = (n_valid_q && !n_used_q) ? n_end_q : r_end_q;

	// entry that re-enters the chain at the top during a rotation
	always_comb begin
		head_in = e[0];
		if (state_q == S_CPASS) begin
			if (e[0].keep) begin
				head_in.seg_start = addr_q[ADDR_BITS-1:0];
				head_in.seg_end   = ADDR_BITS'(addr_q + head_len - SIZE_W'(1));
				head_in.keep      = 1'b0;
			end else if (!hole_q && addr_q < mem_q) begin
				head_in = '{seg_start: addr_q[ADDR_BITS-1:0],
					seg_end: ADDR_BITS'(mem_q - SIZE_W'(1)), used: 1'b0, owner: '0, keep: 1'b0};
			end
		end
	end

	always_comb begin
		cmd = '{mode: CMD_HOLD, pos: '0, phase: k_q[0], wr: wra_d_q};
		case (state_q)
			S_SCAN, S_SUM, S_CPASS: cmd.mode = CMD_ROT;
			S_MARK: cmd.mode = CMD_MARK;
			S_SORT: cmd.mode = CMD_SORT;
			S_EXEC: begin
				if (ins_p_q) begin
					cmd.mode = CMD_INS;
					cmd.pos  = wra_pos_q;
				end else if (wra_p_q) begin
					cmd.mode = CMD_WR;
					cmd.pos  = wra_pos_q;
				end else if (wrb_p_q) begin
					cmd.mode = CMD_WR;
					cmd.pos  = wrb_pos_q;
					cmd.wr   = wrb_d_q;
				end else if (dela_p_q) begin
					cmd.mode = CMD_DEL;
					cmd.pos  = dela_pos_q;
				end else if (delb_p_q) begin
					cmd.mode = CMD_DEL;
					cmd.pos  = delb_pos_q;
				end
			end
			default: cmd.mode = CMD_HOLD;
		endcase
		// register write reinitializes the table to one free segment
		if (cfg_wr) begin
			cmd.mode = CMD_WR;
			cmd.pos  = '0;
			cmd.wr   = '{seg_start: '0, seg_end: ADDR_BITS'(cfg_size - SIZE_W'(1)),
				used: 1'b0, owner: '0, keep: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= CNT_W'(1);
			mem_q       <= MEM_MAX;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			ins_p_q     <= 1'b0;
			wra_p_q     <= 1'b0;
			wrb_p_q     <= 1'b0;
			dela_p_q    <= 1'b0;
			delb_p_q    <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one is loaded this cycle
			if (out_valid_q && out_ready && state_q != S_OUT) out_valid_q <= 1'b0;
			if (cfg_wr) begin
				mem_q   <= cfg_size;
				total_q <= CNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q        <= op;
						owner_q     <= owner_id;
						size_q      <= request_size;
						mode_q      <= fit_mode;
						k_q         <= '0;
						found_q     <= 1'b0;
						pick_len_q  <= '0;
						rel_found_q <= 1'b0;
						need_next_q <= 1'b0;
						n_valid_q   <= 1'b0;
						grant_q     <= '0;
						state_q     <= (op == OP_COMPACT) ? S_MARK : S_SCAN;
					end
				end
				S_SCAN: begin
					last_start_q <= e[0].seg_start;
					last_used_q  <= e[0].used;
					if (op_q == OP_REQUEST && fit) begin
						if (!found_q || (mode_q == FIT_BEST && head_len <= pick_len_q) ||
							(mode_q == FIT_WORST && head_len > pick_len_q)) begin
							found_q      <= 1'b1;
							pick_q       <= k_q;
							pick_start_q <= e[0].seg_start;
							pick_end_q   <= e[0].seg_end;
							pick_len_q   <= head_len;
						end
					end
					if (op_q == OP_RELEASE && in_range) begin
						if (!rel_found_q && e[0].used && e[0].owner == owner_q) begin
							rel_found_q <= 1'b1;
							need_next_q <= 1'b1;
							r_q         <= k_q;
							r_start_q   <= e[0].seg_start;
							r_end_q     <= e[0].seg_end;
							p_start_q   <= last_start_q;
							p_used_q    <= (k_q == '0) ? 1'b1 : last_used_q;
						end
						if (need_next_q) begin
							n_valid_q <= 1'b1;
							n_used_q  <= e[0].used;
							n_end_q   <= e[0].seg_end;
						end
					end
					if (need_next_q) need_next_q <= 1'b0;
					k_q <= k_q + IDX_W'(1);
					if (k_q == IDX_LAST) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					status_q <= ST_OK;
					state_q  <= S_EXEC;
					case (op_q)
						OP_REQUEST: begin
							if (size_q == '0 || mode_q > FIT_WORST) begin
								status_q <= ST_BAD;
							end else if (!found_q) begin
								status_q <= ST_NO_SPACE;
							end else if (pick_len_q == size_q) begin
								wra_p_q   <= 1'b1;
								wra_pos_q <= pick_q;
								wra_d_q   <= '{seg_start: pick_start_q, seg_end: pick_end_q,
									used: 1'b1, owner: owner_q, keep: 1'b0};
								grant_q   <= pick_start_q;
							end else if (total_q >= SEG_FULL) begin
								status_q <= ST_TABLE_FULL;
							end else begin
								ins_p_q   <= 1'b1;
								wra_p_q   <= 1'b1;
								wrb_p_q   <= 1'b1;
								wra_pos_q <= pick_q;
								wrb_pos_q <= pick_q + IDX_W'(1);
								wra_d_q   <= '{seg_start: pick_start_q,
									seg_end: ADDR_BITS'({1'b0, pick_start_q} + size_q - SIZE_W'(1)),
									used: 1'b1, owner: owner_q, keep: 1'b0};
								wrb_d_q   <= '{seg_start: ADDR_BITS'({1'b0, pick_start_q} + size_q),
									seg_end: pick_end_q, used: 1'b0, owner: '0, keep: 1'b0};
								grant_q   <= pick_start_q;
							end
						end
						OP_RELEASE: begin
							if (!rel_found_q) begin
								status_q <= ST_NO_OWNER;
							end else if (p_used_q) begin
								wra_p_q    <= 1'b1;
								wra_pos_q  <= r_q;
								wra_d_q    <= '{seg_start: r_start_q, seg_end: rel_end,
									used: 1'b0, owner: '0, keep: 1'b0};
								dela_p_q   <= n_valid_q && !n_used_q;
								dela_pos_q <= r_q + IDX_W'(1);
							end else begin
								// merge into the free segment below
								wra_p_q    <= 1'b1;
								wra_pos_q  <= r_q - IDX_W'(1);
								wra_d_q    <= '{seg_start: p_start_q, seg_end: rel_end,
									used: 1'b0, owner: '0, keep: 1'b0};
								dela_p_q   <= 1'b1;
								dela_pos_q <= r_q;
								delb_p_q   <= n_valid_q && !n_used_q;
								delb_pos_q <= r_q;
							end
						end
						default: status_q <= ST_BAD;
					endcase
				end
				S_EXEC: begin
					if (ins_p_q) begin
						ins_p_q <= 1'b0;
						total_q <= total_q + CNT_W'(1);
					end else if (wra_p_q) begin
						wra_p_q <= 1'b0;
					end else if (wrb_p_q) begin
						wrb_p_q <= 1'b0;
					end else if (dela_p_q) begin
						dela_p_q <= 1'b0;
						total_q  <= total_q - CNT_W'(1);
					end else if (delb_p_q) begin
						delb_p_q <= 1'b0;
						total_q  <= total_q - CNT_W'(1);
					end else begin
						k_q     <= '0;
						sum_q   <= '0;
						state_q <= S_SUM;
					end
				end
				S_MARK: begin
					status_q <= ST_OK;
					k_q      <= '0;
					state_q  <= S_SORT;
				end
				S_SORT: begin
					k_q <= k_q + IDX_W'(1);
					if (k_q == IDX_LAST) begin
						addr_q  <= '0;
						w_q     <= '0;
						hole_q  <= 1'b0;
						state_q <= S_CPASS;
					end
				end
				S_CPASS: begin
					if (e[0].keep) begin
						addr_q <= addr_q + head_len;
						w_q    <= w_q + CNT_W'(1);
					end else if (!hole_q && addr_q < mem_q) begin
						hole_q <= 1'b1;
					end
					k_q <= k_q + IDX_W'(1);
					if (k_q == IDX_LAST) begin
						total_q <= w_q + CNT_W'(e[0].keep || hole_q ||
							(addr_q < mem_q));
						sum_q   <= '0;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (in_range && !e[0].used) sum_q <= sum_q + head_len;
					k_q <= k_q + IDX_W'(1);
					if (k_q == IDX_LAST) state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_o_q  <= status_q;
						start_o_q   <= (status_q == ST_OK && op_q == OP_REQUEST) ? grant_q : '0;
						free_o_q    <= sum_q;
						count_o_q   <= total_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q != '0) && (total_q <= SEG_FULL))
		else $error("segment count out of range");

	a_no_grant_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_o_q != ST_OK) |-> (start_o_q == '0))
		else $error("start address on a failed transaction");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (free_o_q <= mem_q))
		else $error("free total exceeds memory size");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> (state_q == S_SCAN) || (state_q == S_MARK))
		else $error("accepted transaction did not start a pass");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for contiguous_segment_allocator_top: a table predictor,
// random idling on both channels and APB writes of the pool size. Depends on csa_pkg.
`timescale 1ns / 1ps

module tb_top;
	import csa_pkg::*;

	typedef struct packed {
		logic [1:0]            op;
		logic [OWNER_BITS-1:0] owner;
		logic [SIZE_W-1:0]     size;
		logic [1:0]            fit;
	} alloc_cmd_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ADDR_BITS-1:0] grant;
		logic [SIZE_W-1:0]    free_units;
		logic [CNT_W-1:0]     segs;
	} alloc_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	logic [1:0] op = '0;
	logic [OWNER_BITS-1:0] owner_id = '0;
	logic [SIZE_W-1:0] request_size = '0;
	logic [1:0] fit_mode = '0;
	logic out_valid, out_ready = 1'b0;
	logic [2:0] status;
	logic [ADDR_BITS-1:0] start_address;
	logic [SIZE_W-1:0] free_total;
	logic [CNT_W-1:0] segment_count;

	contiguous_segment_allocator_top uut (.*);

	always #10 clk = ~clk;

	// predictor copy of the segment table
	int unsigned mem_units;
	int unsigned tab_lo [MAX_SEGMENTS];
	int unsigned tab_hi [MAX_SEGMENTS];
	bit          tab_used [MAX_SEGMENTS];
	int unsigned tab_owner [MAX_SEGMENTS];
	int          tab_cnt;

	alloc_cmd_t cmd_q [$];
	alloc_res_t result_q [$];
	int queued_cnt = 0, accepted_cnt = 0, checked_cnt = 0, err_cnt = 0;
	int full_hits = 0, grants = 0;

	function automatic void table_init();
		tab_cnt = 1;
		tab_lo[0] = 0;
		tab_hi[0] = mem_units - 1;
		tab_used[0] = 0;
		tab_owner[0] = 0;
	endfunction

	function automatic void table_remove(int i);
		for (int k = i; k < tab_cnt - 1; k++) begin
			tab_lo[k] = tab_lo[k+1]; tab_hi[k] = tab_hi[k+1];
			tab_used[k] = tab_used[k+1]; tab_owner[k] = tab_owner[k+1];
		end
		tab_cnt--;
	endfunction

	function automatic logic [2:0] table_request(alloc_cmd_t c, output int unsigned grant);
		int pick;
		bit found;
		int unsigned plen, len;
		pick = 0; found = 0; plen = 0; grant = 0;
		if (c.size == 0 || c.fit > FIT_WORST) return ST_BAD;
		for (int i = 0; i < tab_cnt; i++) begin
			if (tab_used[i]) continue;
			len = tab_hi[i] - tab_lo[i] + 1;
			if (len < c.size) continue;
			if (c.fit == FIT_FIRST) begin
				pick = i; plen = len; found = 1;
				break;
			end
			if (!found || (c.fit == FIT_BEST && len <= plen) ||
			    (c.fit == FIT_WORST && len > plen)) begin
				pick = i; plen = len; found = 1;
			end
		end
		if (!found) return ST_NO_SPACE;
		if (plen != c.size) begin
			if (tab_cnt >= MAX_SEGMENTS) return ST_TABLE_FULL;
			for (int k = tab_cnt; k > pick; k--) begin
				tab_lo[k] = tab_lo[k-1]; tab_hi[k] = tab_hi[k-1];
				tab_used[k] = tab_used[k-1]; tab_owner[k] = tab_owner[k-1];
			end
			tab_cnt++;
			tab_hi[pick] = tab_lo[pick] + c.size - 1;
			tab_lo[pick+1] = tab_lo[pick] + c.size;
		end
		tab_used[pick] = 1;
		tab_owner[pick] = c.owner;
		grant = tab_lo[pick];
		return ST_OK;
	endfunction

	function automatic logic [2:0] table_release(int unsigned who);
		int i;
		for (i = 0; i < tab_cnt; i++)
			if (tab_used[i] && tab_owner[i] == who) break;
		if (i >= tab_cnt) return ST_NO_OWNER;
		tab_used[i] = 0;
		tab_owner[i] = 0;
		if (i > 0 && !tab_used[i-1]) begin
			tab_hi[i-1] = tab_hi[i];
			table_remove(i);
			i--;
		end
		if (i + 1 < tab_cnt && !tab_used[i+1]) begin
			tab_hi[i] = tab_hi[i+1];
			table_remove(i + 1);
		end
		return ST_OK;
	endfunction

	function automatic void table_compact();
		int w;
		int unsigned addr, len;
		w = 0; addr = 0;
		for (int r = 0; r < tab_cnt; r++) begin
			if (!tab_used[r]) continue;
			len = tab_hi[r] - tab_lo[r] + 1;
			tab_lo[w] = addr; tab_hi[w] = addr + len - 1;
			tab_used[w] = 1; tab_owner[w] = tab_owner[r];
			addr += len;
			w++;
		end
		if (addr < mem_units && w < MAX_SEGMENTS) begin
			tab_lo[w] = addr; tab_hi[w] = mem_units - 1;
			tab_used[w] = 0; tab_owner[w] = 0;
			w++;
		end
		tab_cnt = w;
	endfunction

	function automatic alloc_res_t table_apply(alloc_cmd_t c);
		alloc_res_t r;
		int unsigned g, fsum;
		g = 0; fsum = 0;
		case (c.op)
			OP_REQUEST: r.status = table_request(c, g);
			OP_RELEASE: r.status = table_release(c.owner);
			OP_COMPACT: begin
				table_compact();
				r.status = ST_OK;
			end
			default: r.status = ST_BAD;
		endcase
		for (int i = 0; i < tab_cnt; i++)
			if (!tab_used[i]) fsum += tab_hi[i] - tab_lo[i] + 1;
		r.grant = (r.status == ST_OK && c.op == OP_REQUEST) ? g[ADDR_BITS-1:0] : '0;
		r.free_units = fsum[SIZE_W-1:0];
		r.segs = tab_cnt[CNT_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(3, 1);
		if (r < 99) return $urandom_range(20, 4);
		return $urandom_range(300, 50);
	endfunction

	// input driver
	int in_gap = 0, in_seen = 0;
	always @(negedge clk) begin
		if (in_valid && in_seen == accepted_cnt) begin
			// hold until accepted
		end else begin
			in_seen = accepted_cnt;
			if (in_gap > 0 || cmd_q.size() == 0) begin
				if (in_gap > 0) in_gap--;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				op <= cmd_q[0].op;
				owner_id <= cmd_q[0].owner;
				request_size <= cmd_q[0].size;
				fit_mode <= cmd_q[0].fit;
				in_gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		alloc_cmd_t c;
		alloc_res_t r;
		if (in_valid && in_ready) begin
			c = cmd_q.pop_front();
			r = table_apply(c);
			if (r.status == ST_TABLE_FULL) full_hits++;
			if (c.op == OP_REQUEST && r.status == ST_OK) grants++;
			result_q.push_back(r);
			accepted_cnt++;
		end
	end

	// output side: random stalls plus one long hold-off
	int out_gap = 0, choke_left = 0;
	bit choked = 0;
	always @(negedge clk) begin
		if (choke_left > 0) begin
			choke_left--;
			out_ready <= 1'b0;
		end else if (!choked && accepted_cnt >= 400) begin
			choked = 1;
			choke_left = 800;
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			out_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		alloc_res_t e;
		if (out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				$error("result transaction with nothing expected");
				err_cnt++;
			end else begin
				e = result_q.pop_front();
				if (status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, status);
					err_cnt++;
				end
				if (start_address !== e.grant) begin
					$error("start_address expected %0d actual %0d", e.grant, start_address);
					err_cnt++;
				end
				if (free_total !== e.free_units) begin
					$error("free_total expected %0d actual %0d", e.free_units, free_total);
					err_cnt++;
				end
				if (segment_count !== e.segs) begin
					$error("segment_count expected %0d actual %0d", e.segs, segment_count);
					err_cnt++;
				end
				checked_cnt++;
			end
		end
	end

	task automatic push_cmd(logic [1:0] o, int unsigned w, int unsigned s, logic [1:0] f);
		alloc_cmd_t c;
		c.op = o;
		c.owner = w[OWNER_BITS-1:0];
		c.size = s[SIZE_W-1:0];
		c.fit = f;
		cmd_q.push_back(c);
		queued_cnt++;
	endtask

	task automatic drain();
		wait (accepted_cnt == queued_cnt && result_q.size() == 0);
		repeat (250) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] a, logic [31:0] d);
		int unsigned v;
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = a; pwdata = d;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		if (a == 3'd0) begin
			v = d;
			if (v == 0) v = 1;
			if (v > MEM_MAX) v = MEM_MAX;
			mem_units = v;
			table_init();
		end
	endtask

	task automatic random_phase(int n, int release_pct, int unsigned max_sz, int owners);
		int r;
		int unsigned w, s;
		logic [1:0] o, f;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 2) o = 2'd3;
			else if (r < 8) o = OP_COMPACT;
			else if (r < 8 + release_pct) o = OP_RELEASE;
			else o = OP_REQUEST;
			w = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(owners - 1);
			r = $urandom_range(99);
			if (r < 3) s = 0;
			else if (r < 9) s = $urandom & 32'h1F_FFFF;
			else s = $urandom_range(max_sz, 1);
			f = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
			push_cmd(o, w, s, f);
		end
	endtask

	initial begin
		mem_units = MEM_MAX;
		table_init();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, bad inputs, exact fit of everything, missing owner
		push_cmd(OP_REQUEST, 1, 0, FIT_FIRST);
		push_cmd(OP_REQUEST, 1, 5, 2'd3);
		push_cmd(2'd3, 1, 5, FIT_FIRST);
		push_cmd(OP_REQUEST, 2, 32'h1F_FFFF, FIT_BEST);
		push_cmd(OP_REQUEST, 255, MEM_MAX, FIT_FIRST);
		push_cmd(OP_REQUEST, 3, 1, FIT_WORST);
		push_cmd(OP_COMPACT, 0, 0, FIT_FIRST);
		push_cmd(OP_RELEASE, 7, 0, FIT_FIRST);
		push_cmd(OP_RELEASE, 255, 0, FIT_FIRST);
		push_cmd(OP_REQUEST, 10, 100, FIT_FIRST);
		push_cmd(OP_REQUEST, 11, 50, FIT_FIRST);
		push_cmd(OP_REQUEST, 12, 100, FIT_FIRST);
		push_cmd(OP_REQUEST, 13, 20, FIT_FIRST);
		push_cmd(OP_RELEASE, 10, 0, FIT_FIRST);
		push_cmd(OP_RELEASE, 12, 0, FIT_FIRST);
		push_cmd(OP_REQUEST, 14, 30, FIT_BEST);
		push_cmd(OP_REQUEST, 15, 30, FIT_WORST);
		push_cmd(OP_REQUEST, 16, 70, FIT_BEST);
		push_cmd(OP_RELEASE, 11, 0, FIT_FIRST);
		push_cmd(OP_COMPACT, 0, 0, FIT_FIRST);
		push_cmd(OP_REQUEST, 0, MEM_MAX - 250, FIT_WORST);
		push_cmd(OP_COMPACT, 0, 0, FIT_FIRST);
		drain();

		apb_write(3'd4, 32'd17); // ignored index
		apb_write(3'd0, 32'd0);
		random_phase(60, 35, 2, 4);
		drain();
		apb_write(3'd0, 32'h1F_FFFF);
		random_phase(250, 30, 1 << 17, 16);
		drain();
		apb_write(3'd0, 32'd60);
		random_phase(300, 15, 3, 64);
		drain();
		apb_write(3'd0, 32'd1000);
		random_phase(300, 35, 80, 24);
		drain();
		apb_write(3'd0, 32'(MEM_MAX));
		random_phase(250, 35, 1 << 16, 256);
		drain();
		apb_write(3'd0, 32'd5);
		random_phase(100, 35, 3, 4);
		drain();
		apb_write(3'd0, 32'd333);
		random_phase(200, 25, 40, 32);
		drain();

		$display("Ran %0d transactions, checked %0d results: %0d grants, %0d table-full refusals.",
			accepted_cnt, checked_cnt, grants, full_hits);
		$display("Covered seven table reloads including both clamped extremes, with a long output hold-off.");
		if (err_cnt == 0 && result_q.size() == 0)
			$display("contiguous_segment_allocator_top: match");
		else
			$display("contiguous_segment_allocator_top: mismatch");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("contiguous_segment_allocator_top: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
sv/csa_pkg.sv
sv/csa_cell.sv
sv/contiguous_segment_allocator_top.sv
bench/tb_top.sv
